[src/dppc_pkg.sv]
// shared types and constants for the depth player pixel colorizer
`timescale 1ns / 1ps
package dppc_pkg;

  localparam int DEPTH_W      = 13;
  localparam int PLAYER_W     = 3;
  localparam int SLOTS        = 6;
  localparam int COUNT_W      = 3;
  localparam int CFG_INDEX_W  = 2;
  localparam int DEPTH_DIVISOR = 4095;

  localparam logic [PLAYER_W-1:0] PLAYER_NONE  = 3'd0;
  localparam logic [PLAYER_W-1:0] PLAYER_SPARE = 3'd7;

  // register indexes of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BINARY_MODE       = 2'd0,
    REG_INVERT_BINARY     = 2'd1,
    REG_GREYSCALE_MODE    = 2'd2,
    REG_REMOVE_BACKGROUND = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [15:0] depth_word;
    logic        frame_last;
  } pixel_t;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               frame_done;
    logic [COUNT_W-1:0] active_count;
    logic [SLOTS-1:0]   active_mask;
  } color_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [7:0]          inten;
    logic [PLAYER_W-1:0] player;
    logic                bg;
    logic                frame_done;
    logic [COUNT_W-1:0]  active_count;
    logic [SLOTS-1:0]    active_mask;
  } cls_t;

  typedef struct packed {
    logic binary_mode;
    logic invert_binary;
    logic greyscale_mode;
    logic remove_background;
  } cfg_t;

endpackage

[src/depth_player_pixel_colorizer.sv]
// top level of the depth player pixel colorizer
//
//   channel  | direction | payload   | handshake
//   ---------+-----------+-----------+----------------------------------
//   pixel    | in        | pixel_t   | pixel_valid / pixel_stall
//   color    | out       | color_t   | color_valid / color_stall
//   cfg      | in        | 1 bit     | cfg_we, cfg_index (write only)
//
// one pixel per clock sustained while pixel_stall is low; the front writes
// the queue at the accepting edge, then the back loads the output register
// from the queue when the output register is empty or color_stall is low
// the front path is an add, a compare and an increment for the divide by 4095
// plus the player mask update, the back path is the colour selection
// synchronous reset clears the configuration, the player mask, the queue
// and the output valid; no clearing pass
// pixel_stall rises only when the queue is full, which happens only while
// color_stall holds the output register
`timescale 1ns / 1ps
module depth_player_pixel_colorizer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  output logic                                pixel_stall,
  input  dppc_pkg::pixel_t                    pixel,
  output logic                                color_valid,
  input  logic                                color_stall,
  output dppc_pkg::color_t                    color,
  input  logic                                cfg_we,
  input  logic [dppc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic                                cfg_data
);
  import dppc_pkg::*;

  cfg_t cfg;
  logic push, pop, q_valid, q_full;
  cls_t push_entry, pop_entry;

  // configuration registers; the user must write them only while idle, the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BINARY_MODE:       cfg.binary_mode       <= cfg_data;
        REG_INVERT_BINARY:     cfg.invert_binary     <= cfg_data;
        REG_GREYSCALE_MODE:    cfg.greyscale_mode    <= cfg_data;
        REG_REMOVE_BACKGROUND: cfg.remove_background <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall comes straight from the queue fill, never from color_stall
  assign pixel_stall = q_full;

  dppc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel       (pixel),
    .q_full      (q_full),
    .push        (push),
    .entry       (push_entry)
  );

  dppc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (push_entry),
    .pop       (pop),
    .dout      (pop_entry),
    .not_empty (q_valid),
    .full      (q_full)
  );

  dppc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .entry       (pop_entry),
    .pop         (pop),
    .color_valid (color_valid),
    .color_stall (color_stall),
    .color       (color)
  );

endmodule

[src/dppc_front.sv]
// front end: accepts pixels, derives intensity and player, tracks players per frame
`timescale 1ns / 1ps
module dppc_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            pixel_valid,
  input  dppc_pkg::pixel_t pixel,
  input  logic            q_full,
  output logic            push,
  output dppc_pkg::cls_t  entry
);
  import dppc_pkg::*;

  logic [SLOTS-1:0]    players_seen;
  logic [SLOTS-1:0]    players_seen_next;
  logic [DEPTH_W-1:0]  depth;
  logic [PLAYER_W-1:0] player;
  logic                bg;
  logic [8:0]          quot_lo;
  logic [12:0]         rem;
  logic                rem_ge;
  logic [7:0]          quot;
  logic [COUNT_W-1:0]  pop_count;

  assign depth  = pixel.depth_word[15:3];
  assign player = pixel.depth_word[2:0];
  assign bg     = (player == PLAYER_NONE) || (player == PLAYER_SPARE);

  // 256*d / 4095: first guess d>>4, remainder (d&15)<<8 + guess stays below 2*4095
  assign quot_lo = depth[12:4];
  assign rem     = {1'b0, depth[3:0], 8'h00} + {4'b0, quot_lo};
  assign rem_ge  = rem >= 13'(DEPTH_DIVISOR);
  assign quot    = quot_lo[7:0] + {7'b0, rem_ge};

  assign players_seen_next = bg ? players_seen
                                : players_seen | (SLOTS'(1) << (player - 3'd1));

  always_comb begin
    pop_count = '0;
    for (int i = 0; i < SLOTS; i++) begin
      pop_count = pop_count + COUNT_W'(players_seen_next[i]);
    end
  end

  assign push = pixel_valid && !q_full;

  always_comb begin
    entry.inten        = 8'hFF - quot;
    entry.player       = player;
    entry.bg           = bg;
    entry.frame_done   = pixel.frame_last;
    entry.active_count = pixel.frame_last ? pop_count : '0;
    entry.active_mask  = pixel.frame_last ? players_seen_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      players_seen <= '0;
    end else if (push) begin
      players_seen <= pixel.frame_last ? '0 : players_seen_next;
    end
  end

endmodule

[src/dppc_queue.sv]
// short queue of classified pixels between front and back
`timescale 1ns / 1ps
module dppc_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dppc_pkg::cls_t din,
  input  logic           pop,
  output dppc_pkg::cls_t dout,
  output logic           not_empty,
  output logic           full
);
  import dppc_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cls_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign not_empty = count != '0;
  assign full      = count == CNT_W'(DEPTH);
  assign dout      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wrap_inc(wr_ptr);
      if (pop)  rd_ptr <= wrap_inc(rd_ptr);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

[src/dppc_back.sv]
// back end: turns a classified pixel into rgb and holds the output register
`timescale 1ns / 1ps
module dppc_back (
  input  logic            clk,
  input  logic            rst,
  input  dppc_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  dppc_pkg::cls_t  entry,
  output logic            pop,
  output logic            color_valid,
  input  logic            color_stall,
  output dppc_pkg::color_t color
);
  import dppc_pkg::*;

  logic [7:0] r, g, b;
  logic [7:0] half, quarter, level;
  logic       blank;

  assign half    = entry.inten >> 1;
  assign quarter = entry.inten >> 2;
  assign blank   = entry.bg && cfg.remove_background;

  always_comb begin
    r = '0;
    g = '0;
    b = '0;
    level = '0;
    if (cfg.binary_mode) begin
      level = (blank ^ cfg.invert_binary) ? 8'h00 : 8'hFF;
      r = level; g = level; b = level;
    end else if (cfg.greyscale_mode) begin
      level = blank ? 8'h00 : entry.inten;
      r = level; g = level; b = level;
    end else begin
      case (entry.player)
        3'd0: begin
          level = cfg.remove_background ? 8'h00 : half;
          r = level; g = level; b = level;
        end
        3'd1: r = entry.inten;
        3'd2: g = entry.inten;
        3'd3: begin r = quarter; g = entry.inten; b = entry.inten; end
        3'd4: begin r = entry.inten; g = entry.inten; b = quarter; end
        3'd5: begin r = entry.inten; g = quarter; b = entry.inten; end
        3'd6: begin r = half; g = half; b = entry.inten; end
        default: begin
          level = cfg.remove_background ? 8'h00 : 8'hFF - half;
          r = level; g = level; b = level;
        end
      endcase
    end
  end

  assign pop = q_valid && (!color_valid || !color_stall);

  always_ff @(posedge clk) begin
    if (pop) begin
      color.red          <= r;
      color.green        <= g;
      color.blue         <= b;
      color.frame_done   <= entry.frame_done;
      color.active_count <= entry.active_count;
      color.active_mask  <= entry.active_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
    end else if (pop) begin
      color_valid <= 1'b1;
    end else if (!color_stall) begin
      color_valid <= 1'b0;
    end
  end

endmodule

[src/dppc_checker.sv]
// port level checks for the depth player pixel colorizer, bound to the top level
`timescale 1ns / 1ps
module dppc_checker (
  input logic             clk,
  input logic             rst,
  input logic             color_valid,
  input logic             color_stall,
  input dppc_pkg::color_t color
);
  import dppc_pkg::*;

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    color_valid && color_stall |=> color_valid && $stable(color))
    else $error("stalled color transaction changed");

  // counts only at a frame end
  a_counts_zero: assert property (@(posedge clk) disable iff (rst)
    color_valid && !color.frame_done |-> color.active_count == '0 && color.active_mask == '0)
    else $error("player counts outside frame end");

  // count matches the mask population
  a_count_mask: assert property (@(posedge clk) disable iff (rst)
    color_valid |-> 32'(color.active_count) == $countones(color.active_mask))
    else $error("active_count disagrees with active_mask");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !color_valid)
    else $error("color_valid after reset");

endmodule

bind depth_player_pixel_colorizer dppc_checker u_dppc_checker (
  .clk         (clk),
  .rst         (rst),
  .color_valid (color_valid),
  .color_stall (color_stall),
  .color       (color)
);

[tb/tb_depth_player_pixel_colorizer.sv]
// testbench for the depth player pixel colorizer: directed and random stimulus checked against a predictor
`timescale 1ns / 1ps
module tb_depth_player_pixel_colorizer;
  import dppc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int IDLE_PERCENT  = 21;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_PIXELS  = 108;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   pixel_valid = 1'b0;
  logic   pixel_stall;
  pixel_t pixel = '0;
  logic   color_valid;
  logic   color_stall = 1'b0;
  color_t color;
  logic   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic   cfg_data = 1'b0;

  // pixels waiting to be driven and colors waiting to come out
  pixel_t pixels_to_send[$];
  color_t expected_colors[$];

  // predictor copy of the register file and the per-frame player mask
  cfg_t           mode_regs = '0;
  logic [SLOTS-1:0] players_seen = '0;

  int unsigned cycles = 0;
  int unsigned pixels_accepted = 0;
  int unsigned colors_checked = 0;
  int unsigned frames_closed = 0;
  int unsigned settings_used = 0;
  int unsigned mismatches = 0;

  // a recurring quiet window where neither side idles
  wire calm = (cycles % 3000) < 500;

  depth_player_pixel_colorizer u_top (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .color_valid (color_valid),
    .color_stall (color_stall),
    .color       (color),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected color for one pixel; also folds its player into the frame mask
  function automatic color_t colorize_pixel(pixel_t px);
    logic [DEPTH_W-1:0]  depth;
    logic [PLAYER_W-1:0] player;
    logic                bg;
    int unsigned         quot;
    logic [7:0]          inten;
    logic [7:0]          half;
    logic [7:0]          quarter;
    logic [7:0]          shade;
    color_t              c;
    depth   = px.depth_word[15:3];
    player  = px.depth_word[PLAYER_W-1:0];
    bg      = (player == PLAYER_NONE) || (player == PLAYER_SPARE);
    // divide by 4095 can exceed 255 for the largest depths; keep the low byte
    quot    = (256 * int'(depth)) / DEPTH_DIVISOR;
    inten   = 8'd255 - quot[7:0];
    half    = inten >> 1;
    quarter = inten >> 2;
    c = '0;
    if (!bg) players_seen[player - 1] = 1'b1;

    if (mode_regs.binary_mode) begin
      // silhouette: background only where the non-player pixels are removed
      if (bg && mode_regs.remove_background) shade = mode_regs.invert_binary ? 8'd255 : 8'd0;
      else shade = mode_regs.invert_binary ? 8'd0 : 8'd255;
      c.red = shade; c.green = shade; c.blue = shade;
    end else if (mode_regs.greyscale_mode) begin
      shade = (bg && mode_regs.remove_background) ? 8'd0 : inten;
      c.red = shade; c.green = shade; c.blue = shade;
    end else begin
      case (player)
        PLAYER_NONE: begin
          if (!mode_regs.remove_background) begin
            c.red = half; c.green = half; c.blue = half;
          end
        end
        3'd1: c.red = inten;
        3'd2: c.green = inten;
        3'd3: begin
          c.red = quarter; c.green = inten; c.blue = inten;
        end
        3'd4: begin
          c.red = inten; c.green = inten; c.blue = quarter;
        end
        3'd5: begin
          c.red = inten; c.green = quarter; c.blue = inten;
        end
        3'd6: begin
          c.red = half; c.green = half; c.blue = inten;
        end
        default: begin
          // spare index: bright inverse of half intensity
          if (!mode_regs.remove_background) begin
            shade = 8'd255 - half;
            c.red = shade; c.green = shade; c.blue = shade;
          end
        end
      endcase
    end

    c.frame_done = px.frame_last;
    if (px.frame_last) begin
      c.active_count = COUNT_W'($countones(players_seen));
      c.active_mask  = players_seen;
      players_seen   = '0;
    end
    return c;
  endfunction

  function automatic pixel_t make_pixel(int unsigned depth, int unsigned player, bit last);
    pixel_t px;
    px.depth_word = {depth[DEPTH_W-1:0], player[PLAYER_W-1:0]};
    px.frame_last = last;
    return px;
  endfunction

  // random pixel: mostly raw words, some depths near the divide boundary
  function automatic pixel_t random_pixel();
    int unsigned edges[8] = '{0, 1, 2047, 4094, 4095, 4096, 8190, 8191};
    pixel_t px;
    bit     last;
    last = ($urandom_range(9) == 0);
    if ($urandom_range(99) < 70) begin
      px.depth_word = 16'($urandom());
      px.frame_last = last;
    end else begin
      px = make_pixel(edges[$urandom_range(7)], $urandom_range(7), last);
    end
    return px;
  endfunction

  // append one pixel to the pending list
  task automatic queue_pixel(pixel_t px);
    pixels_to_send = {pixels_to_send, px};
  endtask

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // driver: hold the transaction while stalled, otherwise load the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        expected_colors = {expected_colors, colorize_pixel(pixel)};
        pixels_accepted++;
      end
      if (!pixel_valid || !pixel_stall) begin
        if (pixels_to_send.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
          pixel       <= pixels_to_send.pop_front();
          pixel_valid <= 1'b1;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare every accepted color with the oldest prediction
  always @(posedge clk) begin
    color_t want;
    if (rst) begin
      color_stall <= 1'b0;
    end else begin
      if (color_valid && !color_stall) begin
        if (expected_colors.size() == 0) begin
          $error("color transaction with nothing expected: %h", color);
          mismatches++;
        end else begin
          want = expected_colors.pop_front();
          check_field("red", want.red, color.red);
          check_field("green", want.green, color.green);
          check_field("blue", want.blue, color.blue);
          check_field("frame_done", want.frame_done, color.frame_done);
          check_field("active_count", want.active_count, color.active_count);
          check_field("active_mask", want.active_mask, color.active_mask);
          colors_checked++;
          if (color.frame_done) frames_closed++;
        end
      end
      color_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout with %0d colors outstanding", expected_colors.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // one register write; mirror updated once the write edge has passed
  task automatic write_reg(reg_index_t idx, logic val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_BINARY_MODE:       mode_regs.binary_mode = val;
      REG_INVERT_BINARY:     mode_regs.invert_binary = val;
      REG_GREYSCALE_MODE:    mode_regs.greyscale_mode = val;
      REG_REMOVE_BACKGROUND: mode_regs.remove_background = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(cfg_t s);
    write_reg(REG_BINARY_MODE, s.binary_mode);
    write_reg(REG_INVERT_BINARY, s.invert_binary);
    write_reg(REG_GREYSCALE_MODE, s.greyscale_mode);
    write_reg(REG_REMOVE_BACKGROUND, s.remove_background);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // wait until every queued pixel has gone in and its color has come out;
  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_idle();
    while (pixels_to_send.size() != 0 || pixel_valid || expected_colors.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    cfg_t s;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: colour table mode, every player, depth extremes
    apply_settings('0);
    for (int p = 0; p < 8; p++) queue_pixel(make_pixel(0, p, p == 7));
    // frame with no players at all
    queue_pixel(make_pixel(8191, 0, 0));
    queue_pixel(make_pixel(8191, 7, 1));
    // depths around the 4095 wrap point
    queue_pixel(make_pixel(4095, 1, 0));
    queue_pixel(make_pixel(4094, 2, 0));
    queue_pixel(make_pixel(4096, 3, 0));
    queue_pixel(make_pixel(8190, 4, 0));
    queue_pixel(make_pixel(2047, 5, 0));
    queue_pixel(make_pixel(1, 6, 1));
    // all ones word, then a lone single-pixel frame
    queue_pixel(make_pixel(8191, 7, 0));
    queue_pixel(make_pixel(0, 0, 1));
    queue_pixel(make_pixel(4095, 3, 1));
    wait_idle();

    // random: every combination of the four mode bits, all-off and all-on among them
    for (int phase = 0; phase < 16; phase++) begin
      s = cfg_t'(phase[3:0]);
      apply_settings(s);
      for (int i = 0; i < PHASE_PIXELS; i++) queue_pixel(random_pixel());
      wait_idle();
    end

    $display("checked %0d colors from %0d pixels, %0d frames closed",
             colors_checked, pixels_accepted, frames_closed);
    $display("covered %0d register settings and %0d cycles", settings_used, cycles);
    if (mismatches == 0 && expected_colors.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
